FILE: src/cicd_pkg.sv
// Shared types, constants and helpers for the CIC decimator.
// No dependencies; imported by cicd_stage and cic_decimator_unit.
package cicd_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int STAGES_W  = 3;
  localparam int DECIM_W   = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;
  localparam int SHIFT_W   = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 1'b1;

  // Reset values of the configuration registers
  localparam logic [STAGES_W-1:0] NUM_STAGES_RST = 3'd3;
  localparam logic [DECIM_W-1:0]  DECIMATION_RST = 10'd16;

  // Ratio thresholds and the output shift that goes with each band
  localparam logic [DECIM_W-1:0] RATIO_T0 = 10'd16;
  localparam logic [DECIM_W-1:0] RATIO_T1 = 10'd20;
  localparam logic [DECIM_W-1:0] RATIO_T2 = 10'd30;
  localparam logic [DECIM_W-1:0] RATIO_T3 = 10'd40;
  localparam logic [SHIFT_W-1:0] SHIFT_B0 = 5'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_B1 = 5'd6;
  localparam logic [SHIFT_W-1:0] SHIFT_B2 = 5'd10;
  localparam logic [SHIFT_W-1:0] SHIFT_B3 = 5'd14;
  localparam logic [SHIFT_W-1:0] SHIFT_B4 = 5'd18;

  typedef enum logic {
    STAGE_INTEG,
    STAGE_COMB
  } stage_kind_t;

  function automatic logic [SHIFT_W-1:0] shift_for_ratio(input logic [DECIM_W-1:0] ratio);
    logic [SHIFT_W-1:0] s;
    if (ratio < RATIO_T0) begin
      s = SHIFT_B0;
    end else if (ratio < RATIO_T1) begin
      s = SHIFT_B1;
    end else if (ratio < RATIO_T2) begin
      s = SHIFT_B2;
    end else if (ratio < RATIO_T3) begin
      s = SHIFT_B3;
    end else begin
      s = SHIFT_B4;
    end
    return s;
  endfunction

endpackage

FILE: src/cic_decimator_unit.sv
// Top level of the CIC decimation filter.
// Depends on cicd_pkg and instantiates cicd_stage for every integrator and comb.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry input samples (signed 32 bit). A transaction
//   completes at a rising edge with tvalid and tready both high.
//   m_tvalid/m_tready/m_tdata carry decimated output samples (signed 32 bit).
//   cfg_wr_en/cfg_addr/cfg_wdata write num_stages (index 0) and decimation
//   (index 1); write them only while the pipeline is empty.
// Throughput: one input sample per cycle while m_tready is high; each stage
//   (integrator or comb) has a single adder, so no stage limits the rate.
// Path: before m_tvalid rises, an accepted sample passes MAX_STAGE_COUNT
//   integrator registers (the first loaded at the accepting edge),
//   MAX_STAGE_COUNT comb registers and the output register; stages beyond
//   num_stages pass data through.
// Reset (rst, synchronous): clears all integrators, comb delays, the phase
//   counter and every valid flag; num_stages returns to 3, decimation to 16.
// Stall: when m_tready is low the output holds; stages behind it keep filling
//   empty slots, so s_tready drops only once the whole pipeline is full.
module cic_decimator_unit
  import cicd_pkg::*;
#(
  parameter int MAX_STAGE_COUNT = 6,
  parameter int DATA_WIDTH      = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample_in
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SAMPLE_W-1:0]   m_tdata    // [31:0] sample_out
);

  localparam int CNT_W_RAW = $clog2(MAX_STAGE_COUNT + 1);
  localparam int CNT_W     = (CNT_W_RAW > STAGES_W) ? CNT_W_RAW : STAGES_W;
  localparam int EXT_W     = (DATA_WIDTH > SAMPLE_W) ? DATA_WIDTH : SAMPLE_W;

  // Configuration registers
  logic [STAGES_W-1:0] num_stages;
  logic [DECIM_W-1:0]  decimation;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages <= NUM_STAGES_RST;
      decimation <= DECIMATION_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_NUM_STAGES: num_stages <= cfg_wdata[STAGES_W-1:0];
        CFG_DECIMATION: decimation <= cfg_wdata[DECIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage count in use: zero acts as one, saturate at the built depth
  logic [CNT_W-1:0] ns_ext;
  logic [CNT_W-1:0] n_eff;
  logic [MAX_STAGE_COUNT-1:0] stage_on;

  assign ns_ext = CNT_W'(num_stages);

  always_comb begin
    if (ns_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (ns_ext > CNT_W'(MAX_STAGE_COUNT)) begin
      n_eff = CNT_W'(MAX_STAGE_COUNT);
    end else begin
      n_eff = ns_ext;
    end
  end

  for (genvar j = 0; j < MAX_STAGE_COUNT; j++) begin : g_on
    assign stage_on[j] = CNT_W'(j) < n_eff;
  end

  // Decimation ratio: zero acts as one
  logic [DECIM_W-1:0]  ratio;
  logic [SHIFT_W-1:0]  shamt;

  assign ratio = (decimation == '0) ? DECIM_W'(1) : decimation;
  assign shamt = shift_for_ratio(ratio);

  // Integrator chain
  logic [DATA_WIDTH-1:0] in_ext;
  logic [EXT_W-1:0]      in_wide;
  logic                  int_valid [MAX_STAGE_COUNT];
  logic                  int_ready [MAX_STAGE_COUNT];
  logic [DATA_WIDTH-1:0] int_data  [MAX_STAGE_COUNT];
  logic                  int_out_ready;

  assign in_wide = EXT_W'($signed(s_tdata));
  assign in_ext  = in_wide[DATA_WIDTH-1:0];

  for (genvar j = 0; j < MAX_STAGE_COUNT; j++) begin : g_int
    logic                  up_valid;
    logic [DATA_WIDTH-1:0] up_data;
    logic                  dn_ready;

    if (j == 0) begin : g_first
      assign up_valid = s_tvalid;
      assign up_data  = in_ext;
      assign s_tready = int_ready[0];
    end else begin : g_next
      assign up_valid = int_valid[j-1];
      assign up_data  = int_data[j-1];
    end

    if (j == MAX_STAGE_COUNT - 1) begin : g_last
      assign dn_ready = int_out_ready;
    end else begin : g_mid
      assign dn_ready = int_ready[j+1];
    end

    cicd_stage #(
      .KIND       (STAGE_INTEG),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_int (
      .clk       (clk),
      .rst       (rst),
      .active    (stage_on[j]),
      .in_valid  (up_valid),
      .in_ready  (int_ready[j]),
      .in_data   (up_data),
      .out_valid (int_valid[j]),
      .out_ready (dn_ready),
      .out_data  (int_data[j])
    );
  end

  // Rate change: drop samples until the phase counter wraps
  logic [DECIM_W-1:0] phase_count;
  logic [DECIM_W:0]   phase_inc;
  logic               drop;
  logic               comb_in_valid;
  logic               comb_ready [MAX_STAGE_COUNT];
  logic               comb_valid [MAX_STAGE_COUNT];
  logic [DATA_WIDTH-1:0] comb_data [MAX_STAGE_COUNT];

  assign phase_inc     = {1'b0, phase_count} + (DECIM_W + 1)'(1);
  assign drop          = phase_inc < {1'b0, ratio};
  assign int_out_ready = drop || comb_ready[0];
  assign comb_in_valid = int_valid[MAX_STAGE_COUNT-1] && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
    end else if (int_valid[MAX_STAGE_COUNT-1] && int_out_ready) begin
      phase_count <= drop ? phase_inc[DECIM_W-1:0] : '0;
    end
  end

  // Comb chain
  logic out_load;
  logic last_ready;

  assign last_ready = !m_tvalid || m_tready;

  for (genvar j = 0; j < MAX_STAGE_COUNT; j++) begin : g_comb
    logic                  up_valid;
    logic [DATA_WIDTH-1:0] up_data;
    logic                  dn_ready;

    if (j == 0) begin : g_first
      assign up_valid = comb_in_valid;
      assign up_data  = int_data[MAX_STAGE_COUNT-1];
    end else begin : g_next
      assign up_valid = comb_valid[j-1];
      assign up_data  = comb_data[j-1];
    end

    if (j == MAX_STAGE_COUNT - 1) begin : g_last
      assign dn_ready = last_ready;
    end else begin : g_mid
      assign dn_ready = comb_ready[j+1];
    end

    cicd_stage #(
      .KIND       (STAGE_COMB),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_comb (
      .clk       (clk),
      .rst       (rst),
      .active    (stage_on[j]),
      .in_valid  (up_valid),
      .in_ready  (comb_ready[j]),
      .in_data   (up_data),
      .out_valid (comb_valid[j]),
      .out_ready (dn_ready),
      .out_data  (comb_data[j])
    );
  end

  // Output register: arithmetic shift of the last comb value, low 32 bits
  logic signed [EXT_W-1:0] comb_ext;
  logic signed [EXT_W-1:0] shifted;

  assign comb_ext = EXT_W'($signed(comb_data[MAX_STAGE_COUNT-1]));
  assign shifted  = comb_ext >>> shamt;
  assign out_load = comb_valid[MAX_STAGE_COUNT-1] && last_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= shifted[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: src/cicd_stage.sv
// One pipelined CIC stage: an integrator or a comb with differential delay one.
// Depends on cicd_pkg for the stage kind.
module cicd_stage
  import cicd_pkg::*;
#(
  parameter stage_kind_t KIND       = STAGE_INTEG,
  parameter int          DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_data
);

  logic [DATA_WIDTH-1:0] state;
  logic [DATA_WIDTH-1:0] state_next;
  logic [DATA_WIDTH-1:0] result;
  logic                  load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    case (KIND)
      STAGE_INTEG: begin
        result     = state + in_data;
        state_next = result;
      end
      STAGE_COMB: begin
        result     = in_data - state;
        state_next = in_data;
      end
      default: begin
        result     = in_data;
        state_next = state;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      // inactive stages pass the value straight through and hold their state
      if (active) begin
        state <= state_next;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= active ? result : in_data;
    end
  end

endmodule

FILE: bench/cic_decimator_checker.sv
`timescale 1ns / 1ps
// Checker for cic_decimator_unit: watches the config port and both streams,
// predicts every decimated sample and compares it with the output stream.
// Depends on cicd_pkg for widths and register indexes.
module cic_decimator_checker
  import cicd_pkg::*;
#(
  parameter int STAGE_SLOTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample_in
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [SAMPLE_W-1:0]   m_tdata,   // [31:0] sample_out
  output int                    errors,
  output int                    pending,
  output int                    samples_seen,
  output int                    outputs_seen
);

  logic [SAMPLE_W-1:0] integ_acc [STAGE_SLOTS];
  logic [SAMPLE_W-1:0] comb_prev [STAGE_SLOTS];
  logic [DECIM_W-1:0]  phase_cnt;
  logic [STAGES_W-1:0] stages_reg;
  logic [DECIM_W-1:0]  decim_reg;
  logic [SAMPLE_W-1:0] expected_samples [$];

  function automatic int unsigned output_shift(input int unsigned ratio);
    int unsigned sh;
    sh = 18;
    if (ratio < 40) sh = 14;
    if (ratio < 30) sh = 10;
    if (ratio < 20) sh = 6;
    if (ratio < 16) sh = 4;
    return sh;
  endfunction

  task automatic clear_filter();
    for (int j = 0; j < STAGE_SLOTS; j++) begin
      integ_acc[j] = '0;
      comb_prev[j] = '0;
    end
    phase_cnt  = '0;
    stages_reg = 3'd3;
    decim_reg  = 10'd16;
    expected_samples.delete();
  endtask

  // Run one sample through the integrators; on a decimation step run the
  // combs and queue the scaled output.
  task automatic advance_filter(input logic [SAMPLE_W-1:0] x);
    int unsigned n;
    int unsigned ratio;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] d;
    logic signed [SAMPLE_W-1:0] sv;
    n = (stages_reg == 0) ? 1 : ((stages_reg > STAGE_SLOTS) ? STAGE_SLOTS : stages_reg);
    ratio = (decim_reg == 0) ? 1 : decim_reg;
    integ_acc[0] = integ_acc[0] + x;
    for (int j = 1; j < n; j++) integ_acc[j] = integ_acc[j] + integ_acc[j-1];
    if (phase_cnt + 1 < ratio) begin
      phase_cnt = phase_cnt + 1'b1;
      return;
    end
    phase_cnt = '0;
    v = integ_acc[n-1];
    for (int j = 0; j < n; j++) begin
      d = v - comb_prev[j];
      comb_prev[j] = v;
      v = d;
    end
    sv = v;
    expected_samples.push_back(sv >>> output_shift(ratio));
  endtask

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      clear_filter();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_NUM_STAGES) stages_reg = cfg_wdata[STAGES_W-1:0];
        else if (cfg_addr == CFG_DECIMATION) decim_reg = cfg_wdata[DECIM_W-1:0];
      end
      // compare outputs first so an output never matches a sample of this edge
      if (m_tvalid && m_tready) begin
        outputs_seen++;
        if (expected_samples.size() == 0) begin
          errors++;
          $error("sample_out: unexpected output %h, nothing expected", m_tdata);
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want) begin
            errors++;
            $error("sample_out mismatch: expected %h, actual %h", want, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        samples_seen++;
        advance_filter(s_tdata);
      end
    end
    pending <= expected_samples.size();
  end

endmodule

FILE: bench/cic_decimator_unit_test.sv
`timescale 1ns / 1ps
// Top of the cic_decimator_unit testbench: clock, reset, config writes and
// sample stimulus with random backpressure; checking lives in cic_decimator_checker.
// Depends on cicd_pkg, cic_decimator_unit and cic_decimator_checker.
module cic_decimator_unit_test;
  import cicd_pkg::*;

  localparam int STAGE_SLOTS    = 6;
  // pipeline depth from the unit header (2*stages + output reg) plus margin
  localparam int FLUSH_CYCLES   = 2 * STAGE_SLOTS + 5;
  localparam int RANDOM_SAMPLES = 1800;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata   = '0;   // [31:0] sample_in
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;          // [31:0] sample_out

  int                  errors;
  int                  pending;
  int                  samples_seen;
  int                  outputs_seen;
  int                  settings_used = 0;
  bit                  steady_sender = 1'b0;
  logic [SAMPLE_W-1:0] dc_level      = '0;

  always #5 clk = ~clk;

  cic_decimator_unit #(
    .MAX_STAGE_COUNT(STAGE_SLOTS),
    .DATA_WIDTH     (SAMPLE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cic_decimator_checker #(
    .STAGE_SLOTS(STAGE_SLOTS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .pending     (pending),
    .samples_seen(samples_seen),
    .outputs_seen(outputs_seen)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mix of full-range noise, small signals, rail values and a DC level
  // that drives the integrators into steady wrap-around.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom;
    if (r < 77) return $urandom_range(0, 255) - 128;
    if (r < 87) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return dc_level;
  endfunction

  // Offer one sample and hold it until the transaction completes; tvalid
  // stays high afterward so back-to-back samples stream without a bubble.
  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop tvalid, wait for every expected output, then let samples that
  // produce no output leave the pipeline.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called with the pipeline empty.
  task automatic configure(input logic [STAGES_W-1:0] stages,
                           input logic [DECIM_W-1:0] decim);
    logic [CFG_DATA_W-1:0] word;
    // sometimes leave junk above the stage field; only the low bits count
    word = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1) == 0) word = '0;
    word[STAGES_W-1:0] = stages;
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_NUM_STAGES;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_addr  <= CFG_DECIMATION;
    cfg_wdata <= decim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Output side: ready in stretches of random length, a few very long,
  // broken by stalls of random length.
  initial begin
    int hold;
    int gap;
    while (rst) @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      m_tready <= 1'b1;
      repeat (hold) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int                  sent;
    int                  n_items;
    int                  pause_at;
    int                  r;
    logic [STAGES_W-1:0] st;
    logic [DECIM_W-1:0]  dc;
    logic [SAMPLE_W-1:0] v;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (3 stages, ratio 16): rail values and large swings.
    for (int i = 0; i < 16; i++) begin
      case (i)
        0, 1, 2, 3: v = 32'h7FFF_FFFF;
        4, 5, 6, 7: v = 32'h8000_0000;
        8:          v = 32'h0000_0000;
        9:          v = 32'hFFFF_FFFF;
        default:    v = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
      push_sample(v);
    end
    drain();

    // Stage count zero acts as one; ratio zero emits on every sample.
    configure(3'd0, 10'd0);
    for (int i = 0; i < 3; i++) push_sample(pick_sample());
    drain();

    // Stage count above the maximum saturates; largest ratio, no output yet.
    configure(3'd7, 10'd1023);
    for (int i = 0; i < 4; i++) push_sample(pick_sample());
    drain();

    // Lower the ratio below the running phase: the next sample emits.
    configure(3'd5, 10'd2);
    for (int i = 0; i < 2; i++) push_sample(pick_sample());

    // Random phases, each with its own setting, sender pacing and DC level.
    sent = 0;
    for (int p = 0; sent < RANDOM_SAMPLES; p++) begin
      drain();
      case (p)
        0: begin st = 3'd6; dc = 10'd1023; end
        1: begin st = 3'd1; dc = 10'd1; end
        2: begin st = 3'd6; dc = 10'd1; end
        default: begin
          st = STAGES_W'($urandom_range(0, 7));
          r  = $urandom_range(0, 9);
          if (r == 0)      dc = DECIM_W'($urandom_range(0, 1));
          else if (r < 4)  dc = DECIM_W'($urandom_range(2, 15));
          else if (r == 4) dc = DECIM_W'($urandom_range(16, 19));
          else if (r == 5) dc = DECIM_W'($urandom_range(20, 29));
          else if (r == 6) dc = DECIM_W'($urandom_range(30, 39));
          else if (r == 7) dc = DECIM_W'($urandom_range(40, 64));
          else             dc = DECIM_W'($urandom_range(65, 200));
        end
      endcase
      configure(st, dc);
      if (p == 0) n_items = 1030;
      else if (dc > 40) n_items = dc + $urandom_range(dc, 2 * dc);
      else n_items = $urandom_range(60, 200);
      steady_sender = ($urandom_range(0, 3) == 0);
      dc_level      = $urandom;
      // now and then hold the sender mid-phase until all outputs are in
      pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n_items - 1) : -1;
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) drain();
        push_sample(pick_sample());
      end
      sent += n_items;
    end
    drain();

    if (pending != 0) $error("sample_out: %0d expected outputs never arrived", pending);
    $display("Streamed %0d samples through %0d filter settings, checked %0d decimated outputs.",
             samples_seen, settings_used, outputs_seen);
    if (errors == 0 && pending == 0) begin
      $display("cic_decimator_unit_test passed");
    end else begin
      $display("cic_decimator_unit_test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every gap and stall at max.
  initial begin
    #20ms;
    $display("cic_decimator_unit_test failed");
    $finish;
  end

endmodule
